// ===== src/slgs_pkg.sv =====
// package for the sor laplace grid solver core
// holds widths, register reset values, item and register codes and fsm states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package slgs_pkg;

  localparam int GRID_MAX_DEF = 128;
  localparam int FRAC_BITS    = 16;
  localparam int POT_W        = FRAC_BITS + 9;
  localparam int DISK_W       = FRAC_BITS + 8;
  localparam int OMEGA_W      = 15;
  localparam int OMEGA_FRAC   = 14;
  localparam int RAD_W        = 8;
  localparam int GRID_W       = 8;
  localparam int CENTER_W     = 7;
  localparam int COORD_W      = 7;
  localparam int KIND_W       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int MUL_B_W      = 16;
  localparam int RAD_SQ_W     = 2 * RAD_W;

  localparam logic [GRID_W-1:0]   GRID_USED_RST = 8'd100;
  localparam logic [CENTER_W-1:0] CENTER_RST    = 7'd50;
  localparam logic [RAD_W-1:0]    INNER_RST     = 8'd20;
  localparam logic [RAD_W-1:0]    DISK_IN_RST   = 8'd40;
  localparam logic [RAD_W-1:0]    DISK_OUT_RST  = 8'd44;
  localparam logic [DISK_W-1:0]   DISK_POT_RST  = 24'd6553600;
  localparam logic [OMEGA_W-1:0]  OMEGA_RST     = 15'd24576;
  localparam logic [MUL_B_W-1:0]  OMEGA_ONE     = 16'd16384;

  typedef enum logic [KIND_W-1:0] {
    KIND_INIT  = 2'd0,
    KIND_SWEEP = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_USED = 3'd0,
    CFG_CENTER    = 3'd1,
    CFG_INNER     = 3'd2,
    CFG_DISK_IN   = 3'd3,
    CFG_DISK_OUT  = 3'd4,
    CFG_DISK_POT  = 3'd5,
    CFG_OMEGA     = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_FREE = 2'd0,
    CLS_DISK = 2'd1,
    CLS_GND  = 2'd2
  } cls_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_SQ_I,
    ST_SQ_DI,
    ST_SQ_DO,
    ST_SQ_END,
    ST_I_DR,
    ST_I_DC,
    ST_I_WR,
    ST_S_DR,
    ST_S_LC,
    ST_S_UP,
    ST_S_DN,
    ST_S_RT,
    ST_S_M1,
    ST_S_M2,
    ST_S_AC,
    ST_S_WR
  } state_e;

endpackage

`default_nettype wire

// ===== src/slgs_grid_ram.sv =====
// single port write, single port read grid memory with registered read data
// depends on slgs_pkg for the default data width
`timescale 1ns / 1ps
`default_nettype none

module slgs_grid_ram #(
  parameter int AW = 14,
  parameter int DW = slgs_pkg::POT_W
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/sor_laplace_grid_solver_core.sv =====
// top level of the sor laplace grid solver: config registers, sequencer,
// shared multiplier datapath; depends on slgs_pkg and slgs_grid_ram
//
// usage: a command is taken at a rising edge with start high and busy low.
// kind init writes every cell of the store (fixed cells held, others zero),
// kind sweep runs one in-place over-relaxation pass over the interior of the
// grid in use, kind read returns one cell. every command gives exactly one
// result: potential_o is valid for the single cycle in which done_o is high
// (zero for init, sweep and the unused kind). the receiver cannot stall.
// the sweep is bound by the single read port of the grid memory (three
// neighbour fetches per cell) and the one 27x16 multiplier, used for the
// radius squares, the distance squares and both terms of the update.
// busy is high from an init, sweep or read transfer until done_o; a new
// command may be given in the cycle done_o is high. reset restores register
// defaults and idles the sequencer; the grid holds garbage until an init
// command.
`timescale 1ns / 1ps
`default_nettype none

module sor_laplace_grid_solver_core #(
  parameter int GRID_MAX = slgs_pkg::GRID_MAX_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [slgs_pkg::KIND_W-1:0]       kind_i,
  input  wire logic [slgs_pkg::COORD_W-1:0]      row_i,
  input  wire logic [slgs_pkg::COORD_W-1:0]      col_i,
  output logic                                   done_o,
  output logic signed [slgs_pkg::POT_W-1:0]      potential_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [slgs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [slgs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import slgs_pkg::*;

  localparam int AW   = $clog2(GRID_MAX);
  localparam int CTW  = (AW > COORD_W) ? AW : COORD_W;
  localparam int CW1  = CTW + 1;
  localparam int DRW  = CTW + 2;
  localparam int SQW  = 2 * CTW;
  localparam int D2W  = SQW + 1;
  localparam int CMPW = (D2W > RAD_SQ_W) ? D2W : RAD_SQ_W;
  localparam int GW   = (AW + 1 > GRID_W) ? AW + 1 : GRID_W;
  localparam int SW   = POT_W + 2;
  localparam int PW   = SW + MUL_B_W;
  localparam int P1W  = POT_W + MUL_B_W;
  localparam int TOP  = OMEGA_FRAC + POT_W - 1;

  localparam logic [AW-1:0] IDX_ZERO = AW'(0);
  localparam logic [AW-1:0] IDX_ONE  = AW'(1);
  localparam logic [AW-1:0] IDX_GMAX = AW'(GRID_MAX - 1);
  localparam logic signed [POT_W-1:0] POT_MAX = {1'b0, {(POT_W-1){1'b1}}};
  localparam logic signed [POT_W-1:0] POT_MIN = {1'b1, {(POT_W-1){1'b0}}};

  // configuration registers
  logic [GRID_W-1:0]   grid_used_q;
  logic [CENTER_W-1:0] center_q;
  logic [RAD_W-1:0]    inner_q;
  logic [RAD_W-1:0]    disk_in_q;
  logic [RAD_W-1:0]    disk_out_q;
  logic [DISK_W-1:0]   disk_pot_q;
  logic [OMEGA_W-1:0]  omega_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_used_q <= GRID_USED_RST;
      center_q    <= CENTER_RST;
      inner_q     <= INNER_RST;
      disk_in_q   <= DISK_IN_RST;
      disk_out_q  <= DISK_OUT_RST;
      disk_pot_q  <= DISK_POT_RST;
      omega_q     <= OMEGA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_USED: grid_used_q <= cfg_data_i[GRID_W-1:0];
        CFG_CENTER:    center_q    <= cfg_data_i[CENTER_W-1:0];
        CFG_INNER:     inner_q     <= cfg_data_i[RAD_W-1:0];
        CFG_DISK_IN:   disk_in_q   <= cfg_data_i[RAD_W-1:0];
        CFG_DISK_OUT:  disk_out_q  <= cfg_data_i[RAD_W-1:0];
        CFG_DISK_POT:  disk_pot_q  <= cfg_data_i[DISK_W-1:0];
        CFG_OMEGA:     omega_q     <= cfg_data_i[OMEGA_W-1:0];
        default: ;
      endcase
    end
  end

  // control and datapath registers
  state_e                   state_q, state_d;
  logic                     done_q, done_d;
  logic                     sweep_q, sweep_d;
  logic [AW-1:0]            r_q, r_d, c_q, c_d;
  logic signed [POT_W-1:0]  pot_q, pot_d;
  logic                     rd_ok_q, rd_ok_d;
  logic [RAD_SQ_W-1:0]      ri2_q, ri2_d, rdi2_q, rdi2_d, rdo2_q, rdo2_d;
  logic [SQW-1:0]           dr2_q, dr2_d;
  logic [D2W-1:0]           d2_q, d2_d;
  cls_e                     cls_q, cls_d;
  logic signed [POT_W-1:0]  left_q, left_d, old_q, old_d;
  logic signed [POT_W-1:0]  up_q, up_d, dn_q, dn_d, right_q, right_d, nv_q, nv_d;
  logic signed [SW-1:0]     s_q, s_d;
  logic signed [P1W-1:0]    p1_q, p1_d;
  logic signed [PW-1:0]     prod_q;

  // shared multiplier
  logic signed [SW-1:0]      mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]      prod;

  assign prod = mul_a * mul_b;

  // memory port
  logic                    ram_we;
  logic [2*AW-1:0]         ram_waddr, ram_raddr;
  logic signed [POT_W-1:0] ram_wdata, rdata;

  slgs_grid_ram #(
    .AW (2 * AW),
    .DW (POT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // helpers
  logic [CTW-1:0]           row_ext, col_ext;
  logic                     in_range;
  logic [GW-1:0]            gu_ext, side;
  logic [AW-1:0]            last_idx;
  logic signed [DRW-1:0]    dr, dc;
  logic signed [MUL_B_W-1:0] w_old;
  logic [D2W-1:0]           d2_init;
  cls_e                     cls_init;
  logic signed [PW-1:0]     acc;
  logic signed [POT_W-1:0]  sat_val, wr_val;

  assign row_ext  = CTW'(row_i);
  assign col_ext  = CTW'(col_i);
  assign in_range = ({1'b0, row_ext} < CW1'(GRID_MAX)) && ({1'b0, col_ext} < CW1'(GRID_MAX));

  assign gu_ext   = GW'(grid_used_q);
  assign side     = (gu_ext < GW'(3)) ? GW'(3) :
                    (gu_ext > GW'(GRID_MAX)) ? GW'(GRID_MAX) : gu_ext;
  assign last_idx = AW'(side - GW'(2));

  assign dr    = $signed({2'b00, CTW'(r_q)}) - $signed({2'b00, CTW'(center_q)});
  assign dc    = $signed({2'b00, CTW'(c_q)}) - $signed({2'b00, CTW'(center_q)});
  assign w_old = $signed(OMEGA_ONE - MUL_B_W'(omega_q));

  function automatic cls_e cls_of(input logic [D2W-1:0] d2,
                                  input logic [RAD_SQ_W-1:0] ri2,
                                  input logic [RAD_SQ_W-1:0] rdi2,
                                  input logic [RAD_SQ_W-1:0] rdo2);
    cls_e res;
    if ((CMPW'(d2) <= CMPW'(ri2)) || (CMPW'(d2) > CMPW'(rdo2))) begin
      res = CLS_GND;
    end else if (CMPW'(d2) >= CMPW'(rdi2)) begin
      res = CLS_DISK;
    end else begin
      res = CLS_FREE;
    end
    return res;
  endfunction

  assign d2_init  = D2W'(dr2_q) + D2W'(prod_q[SQW-1:0]);
  assign cls_init = cls_of(d2_init, ri2_q, rdi2_q, rdo2_q);

  // floor((16384-omega)*old + floor(omega*s/4)) / 16384, saturated
  assign acc     = PW'(p1_q) + (prod_q >>> 2);
  assign sat_val = ((acc[PW-1:TOP] == '0) || (acc[PW-1:TOP] == '1)) ? acc[TOP:OMEGA_FRAC] :
                   (acc[PW-1] ? POT_MIN : POT_MAX);

  always_comb begin
    case (cls_q)
      CLS_DISK: wr_val = $signed({1'b0, disk_pot_q});
      CLS_GND:  wr_val = '0;
      default:  wr_val = nv_q;
    endcase
  end

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign potential_o = pot_q;

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    sweep_d   = sweep_q;
    r_d       = r_q;
    c_d       = c_q;
    pot_d     = pot_q;
    rd_ok_d   = rd_ok_q;
    ri2_d     = ri2_q;
    rdi2_d    = rdi2_q;
    rdo2_d    = rdo2_q;
    dr2_d     = dr2_q;
    d2_d      = d2_q;
    cls_d     = cls_q;
    left_d    = left_q;
    old_d     = old_q;
    up_d      = up_q;
    dn_d      = dn_q;
    right_d   = right_q;
    s_d       = s_q;
    p1_d      = p1_q;
    nv_d      = nv_q;
    mul_a     = SW'(dr);
    mul_b     = MUL_B_W'(dr);
    ram_we    = 1'b0;
    ram_waddr = {r_q, c_q};
    ram_wdata = wr_val;
    ram_raddr = {row_ext[AW-1:0], col_ext[AW-1:0]};

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (kind_e'(kind_i))
            KIND_INIT: begin
              sweep_d = 1'b0;
              state_d = ST_SQ_I;
            end
            KIND_SWEEP: begin
              sweep_d = 1'b1;
              state_d = ST_SQ_I;
            end
            KIND_READ: begin
              rd_ok_d = in_range;
              state_d = ST_READ;
            end
            default: begin
              done_d = 1'b1;
              pot_d  = '0;
            end
          endcase
        end
      end
      ST_READ: begin
        done_d  = 1'b1;
        pot_d   = rd_ok_q ? rdata : '0;
        state_d = ST_IDLE;
      end
      ST_SQ_I: begin
        mul_a   = SW'(inner_q);
        mul_b   = MUL_B_W'(inner_q);
        state_d = ST_SQ_DI;
      end
      ST_SQ_DI: begin
        ri2_d   = prod_q[RAD_SQ_W-1:0];
        mul_a   = SW'(disk_in_q);
        mul_b   = MUL_B_W'(disk_in_q);
        state_d = ST_SQ_DO;
      end
      ST_SQ_DO: begin
        rdi2_d  = prod_q[RAD_SQ_W-1:0];
        mul_a   = SW'(disk_out_q);
        mul_b   = MUL_B_W'(disk_out_q);
        state_d = ST_SQ_END;
      end
      ST_SQ_END: begin
        rdo2_d = prod_q[RAD_SQ_W-1:0];
        if (sweep_q) begin
          r_d     = IDX_ONE;
          c_d     = IDX_ONE;
          state_d = ST_S_DR;
        end else begin
          r_d     = IDX_ZERO;
          c_d     = IDX_ZERO;
          state_d = ST_I_DR;
        end
      end
      ST_I_DR: begin
        state_d = ST_I_DC;
      end
      ST_I_DC: begin
        if (c_q == IDX_ZERO) begin
          dr2_d = prod_q[SQW-1:0];
        end
        mul_a   = SW'(dc);
        mul_b   = MUL_B_W'(dc);
        state_d = ST_I_WR;
      end
      ST_I_WR: begin
        ram_we    = 1'b1;
        ram_wdata = (cls_init == CLS_DISK) ? $signed({1'b0, disk_pot_q}) : '0;
        if (c_q == IDX_GMAX) begin
          c_d = IDX_ZERO;
          if (r_q == IDX_GMAX) begin
            done_d  = 1'b1;
            pot_d   = '0;
            state_d = ST_IDLE;
          end else begin
            r_d     = r_q + IDX_ONE;
            state_d = ST_I_DR;
          end
        end else begin
          c_d     = c_q + IDX_ONE;
          state_d = ST_I_DC;
        end
      end
      ST_S_DR: begin
        ram_raddr = {r_q, IDX_ZERO};
        state_d   = ST_S_LC;
      end
      ST_S_LC: begin
        dr2_d     = prod_q[SQW-1:0];
        left_d    = rdata;
        ram_raddr = {r_q, IDX_ONE};
        state_d   = ST_S_UP;
      end
      ST_S_UP: begin
        // first cell of a row takes its old value from the row start fetch
        if (c_q == IDX_ONE) begin
          old_d = rdata;
        end
        mul_a     = SW'(dc);
        mul_b     = MUL_B_W'(dc);
        ram_raddr = {r_q - IDX_ONE, c_q};
        state_d   = ST_S_DN;
      end
      ST_S_DN: begin
        up_d      = rdata;
        d2_d      = D2W'(dr2_q) + D2W'(prod_q[SQW-1:0]);
        ram_raddr = {r_q + IDX_ONE, c_q};
        state_d   = ST_S_RT;
      end
      ST_S_RT: begin
        dn_d      = rdata;
        cls_d     = cls_of(d2_q, ri2_q, rdi2_q, rdo2_q);
        ram_raddr = {r_q, c_q + IDX_ONE};
        state_d   = ST_S_M1;
      end
      ST_S_M1: begin
        right_d = rdata;
        s_d     = SW'(up_q) + SW'(dn_q) + SW'(left_q) + SW'(rdata);
        mul_a   = SW'(old_q);
        mul_b   = w_old;
        state_d = ST_S_M2;
      end
      ST_S_M2: begin
        p1_d    = prod_q[P1W-1:0];
        mul_a   = s_q;
        mul_b   = $signed(MUL_B_W'(omega_q));
        state_d = ST_S_AC;
      end
      ST_S_AC: begin
        nv_d    = sat_val;
        state_d = ST_S_WR;
      end
      ST_S_WR: begin
        ram_we = 1'b1;
        left_d = wr_val;
        old_d  = right_q;
        if (c_q == last_idx) begin
          c_d = IDX_ONE;
          if (r_q == last_idx) begin
            done_d  = 1'b1;
            pot_d   = '0;
            state_d = ST_IDLE;
          end else begin
            r_d     = r_q + IDX_ONE;
            state_d = ST_S_DR;
          end
        end else begin
          c_d     = c_q + IDX_ONE;
          state_d = ST_S_UP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      sweep_q <= 1'b0;
      r_q     <= IDX_ZERO;
      c_q     <= IDX_ZERO;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      sweep_q <= sweep_d;
      r_q     <= r_d;
      c_q     <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pot_q   <= pot_d;
    rd_ok_q <= rd_ok_d;
    ri2_q   <= ri2_d;
    rdi2_q  <= rdi2_d;
    rdo2_q  <= rdo2_d;
    dr2_q   <= dr2_d;
    d2_q    <= d2_d;
    cls_q   <= cls_d;
    left_q  <= left_d;
    old_q   <= old_d;
    up_q    <= up_d;
    dn_q    <= dn_d;
    right_q <= right_d;
    s_q     <= s_d;
    p1_q    <= p1_d;
    nv_q    <= nv_d;
    prod_q  <= prod;
  end

endmodule

`default_nettype wire
